### rtl/mjt_pkg.sv
// Shared constants, types and register codes for the minimum-jerk trajectory point block.
`default_nettype none

package mjt_pkg;

    localparam int TIME_WIDTH     = 32;
    localparam int POSITION_WIDTH = 32;
    localparam int VEL_WIDTH      = POSITION_WIDTH + 2;
    localparam int ACC_WIDTH      = POSITION_WIDTH + 4;
    localparam int PHASE_BITS     = 30;
    localparam int PHASE_WIDTH    = PHASE_BITS + 1;
    localparam int DIFF_WIDTH     = POSITION_WIDTH + 1;
    localparam int ADDR_WIDTH     = 4;
    localparam int DATA_WIDTH     = 32;
    localparam int QUEUE_DEPTH    = 2;

    // register map, one 32-bit word per register
    typedef enum logic [1:0] {
        REG_START_POSITION = 2'd0,
        REG_END_POSITION   = 2'd1,
        REG_WINDOW_START   = 2'd2,
        REG_WINDOW_END     = 2'd3
    } reg_index_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [TIME_WIDTH-1:0] num;
        logic [TIME_WIDTH-1:0] den;
        logic                  phase_one;
        logic                  in_window;
    } request_t;

endpackage

`default_nettype wire

### rtl/mjt_front.sv
// Front end: takes a sample time, clamps it to the window and classifies it.
`default_nettype none

module mjt_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [mjt_pkg::TIME_WIDTH-1:0]  sample_time,
    input  wire logic [mjt_pkg::TIME_WIDTH-1:0]  window_start,
    input  wire logic [mjt_pkg::TIME_WIDTH-1:0]  window_end,
    input  wire logic                            queue_full,
    output logic                                 push,
    output mjt_pkg::request_t                    push_data,
    output logic                                 busy
);

    logic                             valid_reg;
    logic                             valid_next;
    mjt_pkg::request_t                req_reg;
    mjt_pkg::request_t                req_next;
    logic [mjt_pkg::TIME_WIDTH-1:0]   clamped;

    // clamp and phase operands
    always_comb
    begin
        if (sample_time > window_end)
        begin
            clamped = window_end;
        end
        else if (sample_time < window_start)
        begin
            clamped = window_start;
        end
        else
        begin
            clamped = sample_time;
        end
        req_next.num       = clamped - window_start;
        req_next.den       = window_end - window_start;
        req_next.phase_one = (window_end <= window_start) || (req_next.num >= req_next.den);
        req_next.in_window = (sample_time >= window_start) && (sample_time <= window_end);
    end

    assign push       = valid_reg && !queue_full;
    assign push_data  = req_reg;
    assign busy       = valid_reg && queue_full;
    assign valid_next = accept || (valid_reg && queue_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mjt_queue.sv
// Two-entry request queue between the front end and the back end.
`default_nettype none

module mjt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  mjt_pkg::request_t       push_data,
    output logic                    pop,
    output mjt_pkg::request_t       pop_data,
    output logic                    full
);

    mjt_pkg::request_t  entry_reg [mjt_pkg::QUEUE_DEPTH];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    // back end never stalls, so pop whenever something is held
    assign pop      = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'(mjt_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/mjt_div.sv
// Pipelined restoring divider: one quotient bit per stage gives the Q30 phase.
`default_nettype none

module mjt_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  mjt_pkg::request_t                      in_req,
    output logic                                   out_valid,
    output logic [mjt_pkg::PHASE_WIDTH-1:0]        phase,
    output logic                                   out_in_window
);

    localparam int NS = mjt_pkg::PHASE_BITS;
    localparam int TW = mjt_pkg::TIME_WIDTH;

    logic          vld_reg [NS];
    logic [TW-1:0] rem_reg [NS];
    logic [NS-1:0] q_reg   [NS];
    logic [TW-1:0] den_reg [NS];
    logic          one_reg [NS];
    logic          win_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_stage
            logic          src_vld;
            logic [TW-1:0] src_rem;
            logic [NS-1:0] src_q;
            logic [TW-1:0] src_den;
            logic          src_one;
            logic          src_win;
            logic [TW:0]   rem2;
            logic          ge;

            if (g == 0)
            begin : g_first
                assign src_vld = in_valid;
                assign src_rem = in_req.num;
                assign src_q   = '0;
                assign src_den = in_req.den;
                assign src_one = in_req.phase_one;
                assign src_win = in_req.in_window;
            end
            else
            begin : g_next
                assign src_vld = vld_reg[g-1];
                assign src_rem = rem_reg[g-1];
                assign src_q   = q_reg[g-1];
                assign src_den = den_reg[g-1];
                assign src_one = one_reg[g-1];
                assign src_win = win_reg[g-1];
            end

            // shift, compare, subtract
            assign rem2 = {src_rem, 1'b0};
            assign ge   = (rem2 >= {1'b0, src_den});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g] <= ge ? TW'(rem2 - {1'b0, src_den}) : TW'(rem2);
                q_reg[g]   <= {src_q[NS-2:0], ge};
                den_reg[g] <= src_den;
                one_reg[g] <= src_one;
                win_reg[g] <= src_win;
            end
        end
    endgenerate

    assign out_valid     = vld_reg[NS-1];
    assign out_in_window = win_reg[NS-1];
    assign phase         = one_reg[NS-1] ? {1'b1, {NS{1'b0}}} : {1'b0, q_reg[NS-1]};

endmodule

`default_nettype wire

### rtl/mjt_back.sv
// Back end: phase powers, quintic weights, scaling by the travel and saturation.
`default_nettype none

module mjt_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire logic [mjt_pkg::PHASE_WIDTH-1:0]       phase,
    input  wire logic                                  in_in_window,
    input  wire logic [mjt_pkg::POSITION_WIDTH-1:0]    start_position,
    input  wire logic [mjt_pkg::POSITION_WIDTH-1:0]    end_position,
    output logic                                       done,
    output logic [mjt_pkg::POSITION_WIDTH-1:0]         position,
    output logic [mjt_pkg::VEL_WIDTH-1:0]              velocity,
    output logic [mjt_pkg::ACC_WIDTH-1:0]              acceleration,
    output logic                                       in_window
);

    localparam int PW   = mjt_pkg::PHASE_WIDTH;
    localparam int PB   = mjt_pkg::PHASE_BITS;
    localparam int POLY = PW + 9;
    localparam int MAG  = 36;
    localparam int HALF = MAG / 2;
    localparam int DW   = mjt_pkg::DIFF_WIDTH;
    localparam int PROD = DW + MAG;
    localparam int RES  = PROD - PB;
    localparam int SUM  = RES + 2;
    localparam int NST  = 9;
    localparam int POSW = mjt_pkg::POSITION_WIDTH;
    localparam int VELW = mjt_pkg::VEL_WIDTH;
    localparam int ACCW = mjt_pkg::ACC_WIDTH;

    localparam logic signed [POLY-1:0] K6   = POLY'(6);
    localparam logic signed [POLY-1:0] K10  = POLY'(10);
    localparam logic signed [POLY-1:0] K15  = POLY'(15);
    localparam logic signed [POLY-1:0] K30  = POLY'(30);
    localparam logic signed [POLY-1:0] K60  = POLY'(60);
    localparam logic signed [POLY-1:0] K120 = POLY'(120);
    localparam logic signed [POLY-1:0] K180 = POLY'(180);

    localparam logic signed [SUM-1:0] POS_MAX = SUM'((64'sd1 <<< (POSW - 1)) - 64'sd1);
    localparam logic signed [SUM-1:0] POS_MIN = SUM'(-(64'sd1 <<< (POSW - 1)));
    localparam logic signed [SUM-1:0] VEL_MAX = SUM'((64'sd1 <<< (VELW - 1)) - 64'sd1);
    localparam logic signed [SUM-1:0] VEL_MIN = SUM'(-(64'sd1 <<< (VELW - 1)));
    localparam logic signed [SUM-1:0] ACC_MAX = SUM'((64'sd1 <<< (ACCW - 1)) - 64'sd1);
    localparam logic signed [SUM-1:0] ACC_MIN = SUM'(-(64'sd1 <<< (ACCW - 1)));

    // valid and in_window travel alongside the data
    logic vld_reg [NST];
    logic win_reg [NST];

    // power stages
    logic [PW-1:0] p_reg  [4];
    logic [PW-1:0] p2_reg [4];
    logic [PW-1:0] p3_reg [3];
    logic [PW-1:0] p4_reg [2];
    logic [PW-1:0] p5_reg;

    logic [2*PW-1:0] sq;
    logic [2*PW-1:0] cu;
    logic [2*PW-1:0] qu;
    logic [2*PW-1:0] qi;

    // lane 0 position, 1 velocity, 2 acceleration
    logic signed [POLY-1:0] c_reg   [3];
    logic [MAG-1:0]         mag_reg [3];
    logic                   neg_reg [3];
    logic [DW-1:0]          dmag_reg;
    logic [DW+HALF-1:0]     pl_reg  [3];
    logic [DW+HALF-1:0]     ph_reg  [3];
    logic                   neg2_reg [3];
    logic signed [RES:0]    sv_reg  [3];

    logic signed [POLY-1:0] e1, e2, e3, e4, e5;
    logic signed [DW-1:0]   diff;
    logic signed [SUM-1:0]  pos_sum;
    logic signed [SUM-1:0]  vel_sum;
    logic signed [SUM-1:0]  acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg[0] <= in_in_window;
        for (int i = 1; i < NST; i++)
        begin
            win_reg[i] <= win_reg[i-1];
        end
    end

    // successive powers, one multiply per stage
    assign sq = phase * phase;
    assign cu = p2_reg[0] * p_reg[0];
    assign qu = p3_reg[0] * p_reg[1];
    assign qi = p4_reg[0] * p_reg[2];

    always_ff @(posedge clk)
    begin
        p_reg[0]  <= phase;
        p2_reg[0] <= sq[PB +: PW];
        p_reg[1]  <= p_reg[0];
        p2_reg[1] <= p2_reg[0];
        p3_reg[0] <= cu[PB +: PW];
        p_reg[2]  <= p_reg[1];
        p2_reg[2] <= p2_reg[1];
        p3_reg[1] <= p3_reg[0];
        p4_reg[0] <= qu[PB +: PW];
        p_reg[3]  <= p_reg[2];
        p2_reg[3] <= p2_reg[2];
        p3_reg[2] <= p3_reg[1];
        p4_reg[1] <= p4_reg[0];
        p5_reg    <= qi[PB +: PW];
    end

    // quintic weights
    assign e1 = $signed(POLY'(p_reg[3]));
    assign e2 = $signed(POLY'(p2_reg[3]));
    assign e3 = $signed(POLY'(p3_reg[2]));
    assign e4 = $signed(POLY'(p4_reg[1]));
    assign e5 = $signed(POLY'(p5_reg));

    always_ff @(posedge clk)
    begin
        c_reg[0] <= K10 * e3 - K15 * e4 + K6 * e5;
        c_reg[1] <= K30 * e2 - K60 * e3 + K30 * e4;
        c_reg[2] <= K60 * e1 - K180 * e2 + K120 * e3;
    end

    // sign and magnitude of travel and weights
    assign diff = $signed({end_position[POSW-1], end_position})
                - $signed({start_position[POSW-1], start_position});

    always_ff @(posedge clk)
    begin
        dmag_reg <= diff[DW-1] ? DW'(-diff) : DW'(diff);
        for (int l = 0; l < 3; l++)
        begin
            mag_reg[l] <= c_reg[l][POLY-1] ? MAG'(-c_reg[l]) : MAG'(c_reg[l]);
            neg_reg[l] <= c_reg[l][POLY-1] ^ diff[DW-1];
        end
    end

    // two partial products per lane
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            pl_reg[l]   <= dmag_reg * mag_reg[l][HALF-1:0];
            ph_reg[l]   <= dmag_reg * mag_reg[l][MAG-1:HALF];
            neg2_reg[l] <= neg_reg[l];
        end
    end

    // combine, drop fraction bits toward zero, restore sign
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [PROD-1:0] full;
            logic [RES-1:0]  r;
            full = PROD'(pl_reg[l]) + (PROD'(ph_reg[l]) << HALF);
            r    = full[PROD-1:PB];
            sv_reg[l] <= neg2_reg[l] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
    end

    // offset and saturation
    assign pos_sum = $signed(SUM'($signed(start_position))) + $signed(SUM'(sv_reg[0]));
    assign vel_sum = $signed(SUM'(sv_reg[1]));
    assign acc_sum = $signed(SUM'(sv_reg[2]));

    always_ff @(posedge clk)
    begin
        if (pos_sum > POS_MAX)
        begin
            position <= POSW'(POS_MAX);
        end
        else if (pos_sum < POS_MIN)
        begin
            position <= POSW'(POS_MIN);
        end
        else
        begin
            position <= POSW'(pos_sum);
        end
        if (vel_sum > VEL_MAX)
        begin
            velocity <= VELW'(VEL_MAX);
        end
        else if (vel_sum < VEL_MIN)
        begin
            velocity <= VELW'(VEL_MIN);
        end
        else
        begin
            velocity <= VELW'(vel_sum);
        end
        if (acc_sum > ACC_MAX)
        begin
            acceleration <= ACCW'(ACC_MAX);
        end
        else if (acc_sum < ACC_MIN)
        begin
            acceleration <= ACCW'(ACC_MIN);
        end
        else
        begin
            acceleration <= ACCW'(acc_sum);
        end
    end

    assign done      = vld_reg[NST-1];
    assign in_window = win_reg[NST-1];

endmodule

`default_nettype wire

### rtl/min_jerk_trajectory_point.sv
// Top level of the minimum-jerk trajectory point block: registers, front, queue, back.
// One request per clock: start is taken whenever busy is low, and busy stays low in
// normal use because the back end is a fully pipelined path with no stalls. A request
// passes the front register, the queue, the 30-stage phase divider (one quotient bit
// per stage) and the back-end stages before its result appears on done. The receiver
// cannot hold results off: each result is on the ports for exactly one cycle. The user
// must write registers only while no request is in flight; the block does not enforce it.
`default_nettype none

module min_jerk_trajectory_point (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mjt_pkg::ADDR_WIDTH-1:0]        paddr,
    input  wire logic [mjt_pkg::DATA_WIDTH-1:0]        pwdata,
    output logic [mjt_pkg::DATA_WIDTH-1:0]             prdata,
    output logic                                       pready,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [mjt_pkg::TIME_WIDTH-1:0]        sample_time,
    output logic                                       done,
    output logic [mjt_pkg::POSITION_WIDTH-1:0]         position,
    output logic [mjt_pkg::VEL_WIDTH-1:0]              velocity,
    output logic [mjt_pkg::ACC_WIDTH-1:0]              acceleration,
    output logic                                       in_window
);

    logic [mjt_pkg::POSITION_WIDTH-1:0] start_position_reg;
    logic [mjt_pkg::POSITION_WIDTH-1:0] end_position_reg;
    logic [mjt_pkg::TIME_WIDTH-1:0]     window_start_reg;
    logic [mjt_pkg::TIME_WIDTH-1:0]     window_end_reg;
    mjt_pkg::reg_index_t                reg_index;
    logic                               wr_en;

    logic                               accept;
    logic                               push;
    mjt_pkg::request_t                  push_data;
    logic                               pop;
    mjt_pkg::request_t                  pop_data;
    logic                               queue_full;
    logic                               div_valid;
    logic [mjt_pkg::PHASE_WIDTH-1:0]    div_phase;
    logic                               div_in_window;

    // register port
    assign pready    = 1'b1;
    assign reg_index = mjt_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_position_reg <= '0;
            end_position_reg   <= '0;
            window_start_reg   <= '0;
            window_end_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                mjt_pkg::REG_START_POSITION: start_position_reg <= pwdata[mjt_pkg::POSITION_WIDTH-1:0];
                mjt_pkg::REG_END_POSITION:   end_position_reg   <= pwdata[mjt_pkg::POSITION_WIDTH-1:0];
                mjt_pkg::REG_WINDOW_START:   window_start_reg   <= pwdata[mjt_pkg::TIME_WIDTH-1:0];
                mjt_pkg::REG_WINDOW_END:     window_end_reg     <= pwdata[mjt_pkg::TIME_WIDTH-1:0];
                default:                     start_position_reg <= start_position_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_index)
            mjt_pkg::REG_START_POSITION: prdata = start_position_reg;
            mjt_pkg::REG_END_POSITION:   prdata = end_position_reg;
            mjt_pkg::REG_WINDOW_START:   prdata = window_start_reg;
            mjt_pkg::REG_WINDOW_END:     prdata = window_end_reg;
            default:                     prdata = '0;
        endcase
    end

    assign accept = start && !busy;

    mjt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sample_time  (sample_time),
        .window_start (window_start_reg),
        .window_end   (window_end_reg),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data),
        .busy         (busy)
    );

    mjt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full)
    );

    mjt_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (pop),
        .in_req        (pop_data),
        .out_valid     (div_valid),
        .phase         (div_phase),
        .out_in_window (div_in_window)
    );

    mjt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid),
        .phase          (div_phase),
        .in_in_window   (div_in_window),
        .start_position (start_position_reg),
        .end_position   (end_position_reg),
        .done           (done),
        .position       (position),
        .velocity       (velocity),
        .acceleration   (acceleration),
        .in_window      (in_window)
    );

endmodule

`default_nettype wire

### tb/min_jerk_trajectory_point_checker.sv
// Checker for the minimum-jerk trajectory point block: predicts each result and compares.
`timescale 1ns / 100ps

module min_jerk_trajectory_point_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mjt_pkg::ADDR_WIDTH-1:0]      paddr,
    input  wire logic [mjt_pkg::DATA_WIDTH-1:0]      pwdata,
    input  wire logic                                pready,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic [mjt_pkg::TIME_WIDTH-1:0]      sample_time,
    input  wire logic                                done,
    input  wire logic [mjt_pkg::POSITION_WIDTH-1:0]  position,
    input  wire logic [mjt_pkg::VEL_WIDTH-1:0]       velocity,
    input  wire logic [mjt_pkg::ACC_WIDTH-1:0]       acceleration,
    input  wire logic                                in_window,
    output int                                       fail_count,
    output int                                       pending_points
);

    typedef struct packed {
        logic [mjt_pkg::POSITION_WIDTH-1:0] pos;
        logic [mjt_pkg::VEL_WIDTH-1:0]      vel;
        logic [mjt_pkg::ACC_WIDTH-1:0]      acc;
        logic                               in_win;
    } point_t;

    // shadow copy of the registers
    logic signed [mjt_pkg::POSITION_WIDTH-1:0] cfg_start_pos, cfg_end_pos;
    logic [mjt_pkg::TIME_WIDTH-1:0]            cfg_win_start, cfg_win_end;

    point_t expected_points[$];

    // a*c / 2^30, truncated toward zero
    function automatic logic signed [127:0] scale_q30(logic signed [127:0] a,
                                                       logic signed [127:0] c);
        logic signed [127:0] prod;
        logic [127:0]        mag;
        prod = a * c;
        mag  = prod < 0 ? -prod : prod;
        mag  = mag >> mjt_pkg::PHASE_BITS;
        return prod < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [127:0] clip(logic signed [127:0] v, int w);
        logic signed [127:0] hi, lo;
        hi = (128'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic point_t trajectory_point(logic [mjt_pkg::TIME_WIDTH-1:0] t);
        point_t              r;
        logic [63:0]         tc, p, p2, p3, p4, p5;
        logic signed [127:0] d, s, d1, d2, pos, vel, acc;
        tc = t;
        if (tc > cfg_win_end) tc = cfg_win_end;
        else if (tc < cfg_win_start) tc = cfg_win_start;
        if (cfg_win_end <= cfg_win_start || tc - cfg_win_start >= cfg_win_end - cfg_win_start)
            p = 64'd1 << mjt_pkg::PHASE_BITS;
        else
            p = ((tc - cfg_win_start) << mjt_pkg::PHASE_BITS) / (cfg_win_end - cfg_win_start);
        p2 = (p * p) >> mjt_pkg::PHASE_BITS;
        p3 = (p2 * p) >> mjt_pkg::PHASE_BITS;
        p4 = (p3 * p) >> mjt_pkg::PHASE_BITS;
        p5 = (p4 * p) >> mjt_pkg::PHASE_BITS;
        s  = 10 * $signed({64'd0, p3}) - 15 * $signed({64'd0, p4}) + 6 * $signed({64'd0, p5});
        d1 = 30 * $signed({64'd0, p2}) - 60 * $signed({64'd0, p3}) + 30 * $signed({64'd0, p4});
        d2 = 60 * $signed({64'd0, p}) - 180 * $signed({64'd0, p2}) + 120 * $signed({64'd0, p3});
        d   = 128'(cfg_end_pos) - 128'(cfg_start_pos);
        pos = clip(128'(cfg_start_pos) + scale_q30(d, s), mjt_pkg::POSITION_WIDTH);
        vel = clip(scale_q30(d, d1), mjt_pkg::VEL_WIDTH);
        acc = clip(scale_q30(d, d2), mjt_pkg::ACC_WIDTH);
        r.pos    = pos[mjt_pkg::POSITION_WIDTH-1:0];
        r.vel    = vel[mjt_pkg::VEL_WIDTH-1:0];
        r.acc    = acc[mjt_pkg::ACC_WIDTH-1:0];
        r.in_win = (t >= cfg_win_start) && (t <= cfg_win_end);
        return r;
    endfunction

    assign pending_points = expected_points.size();

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        int     errs;
        if (!rst_n)
        begin
            cfg_start_pos <= '0;
            cfg_end_pos   <= '0;
            cfg_win_start <= '0;
            cfg_win_end   <= '0;
            fail_count    <= 0;
            expected_points.delete();
        end
        else
        begin
            errs = 0;
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    mjt_pkg::REG_START_POSITION: cfg_start_pos <= pwdata;
                    mjt_pkg::REG_END_POSITION:   cfg_end_pos   <= pwdata;
                    mjt_pkg::REG_WINDOW_START:   cfg_win_start <= pwdata;
                    mjt_pkg::REG_WINDOW_END:     cfg_win_end   <= pwdata;
                endcase
            end
            // accepted request
            if (start && !busy)
                expected_points.push_back(trajectory_point(sample_time));
            // delivered result
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result with no request waiting");
                    errs++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (position !== want.pos)
                    begin
                        $error("position: expected %h, got %h", want.pos, position);
                        errs++;
                    end
                    if (velocity !== want.vel)
                    begin
                        $error("velocity: expected %h, got %h", want.vel, velocity);
                        errs++;
                    end
                    if (acceleration !== want.acc)
                    begin
                        $error("acceleration: expected %h, got %h", want.acc, acceleration);
                        errs++;
                    end
                    if (in_window !== want.in_win)
                    begin
                        $error("in_window: expected %b, got %b", want.in_win, in_window);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

### tb/min_jerk_trajectory_point_test.sv
// Testbench top for the minimum-jerk trajectory point block: stimulus and verdict.
`timescale 1ns / 100ps

module min_jerk_trajectory_point_test;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [mjt_pkg::ADDR_WIDTH-1:0]     paddr = '0;
    logic [mjt_pkg::DATA_WIDTH-1:0]     pwdata = '0;
    logic [mjt_pkg::DATA_WIDTH-1:0]     prdata;
    logic                               pready;
    logic                               start = 1'b0;
    logic                               busy;
    logic [mjt_pkg::TIME_WIDTH-1:0]     sample_time = '0;
    logic                               done;
    logic [mjt_pkg::POSITION_WIDTH-1:0] position;
    logic [mjt_pkg::VEL_WIDTH-1:0]      velocity;
    logic [mjt_pkg::ACC_WIDTH-1:0]      acceleration;
    logic                               in_window;
    int                                 fail_count, pending_points;

    localparam int DRAIN_CYCLES = 60;

    logic [mjt_pkg::TIME_WIDTH-1:0] win_lo, win_hi;

    always #6 clk = ~clk;

    min_jerk_trajectory_point uut (.*);

    min_jerk_trajectory_point_checker checker_i (.*);

    task automatic write_reg(mjt_pkg::reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = mjt_pkg::ADDR_WIDTH'({idx, 2'b00}); pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // stop requesting, wait until every request has produced its result, then let the pipe empty
    task automatic drain();
        start = 1'b0;
        while (pending_points != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic setup_axis(logic [31:0] sp, logic [31:0] ep,
                              logic [31:0] ws, logic [31:0] we);
        drain();
        write_reg(mjt_pkg::REG_START_POSITION, sp);
        write_reg(mjt_pkg::REG_END_POSITION, ep);
        write_reg(mjt_pkg::REG_WINDOW_START, ws);
        write_reg(mjt_pkg::REG_WINDOW_END, we);
        win_lo = ws;
        win_hi = we;
    endtask

    // one request; start stays high across back-to-back requests
    task automatic send_time(logic [31:0] t, bit gaps);
        int gap;
        gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18)) : 0;
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        sample_time = t;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_time();
        int unsigned k;
        logic [31:0] span;
        k = $urandom_range(0, 9);
        span = win_hi - win_lo;
        if (k == 0) return $urandom;
        if (k == 1) return win_lo - $urandom_range(0, 3);
        if (k == 2) return win_hi + $urandom_range(0, 3);
        if (k == 3) return win_lo;
        if (k == 4) return win_hi;
        if (win_hi <= win_lo) return win_lo;
        return win_lo + ((span == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, span));
    endfunction

    initial
    begin
        logic [31:0] ws, we;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: default registers give a degenerate window at zero
        send_time(32'd0, 0);
        send_time(32'd1, 0);
        send_time(32'hFFFF_FFFF, 0);

        // full range swing, full time range
        setup_axis(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_time(32'd0, 0);
        send_time(32'h8000_0000, 0);
        send_time(32'h5555_5555, 0);
        send_time(32'hFFFF_FFFF, 0);

        // reverse swing with clamping on both sides
        setup_axis(32'h7FFF_FFFF, 32'h8000_0000, 32'd1000, 32'd2000);
        send_time(32'd0, 0);
        send_time(32'd999, 0);
        send_time(32'd1000, 0);
        send_time(32'd1500, 0);
        send_time(32'd2000, 0);
        send_time(32'd2001, 0);
        send_time(32'hFFFF_FFFF, 0);

        // degenerate windows: equal and inverted
        setup_axis(32'h0001_0000, 32'hFFFF_0000, 32'd500, 32'd500);
        send_time(32'd499, 0);
        send_time(32'd500, 0);
        send_time(32'd501, 0);
        setup_axis(32'h0001_0000, 32'hFFFF_0000, 32'd700, 32'd300);
        send_time(32'd300, 0);
        send_time(32'd500, 0);
        send_time(32'd700, 0);
        // one-tick window
        setup_axis(32'h0, 32'h0010_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_time(32'hFFFF_FFFE, 0);
        send_time(32'hFFFF_FFFF, 0);

        // random phases of random settings
        for (int ph = 0; ph < 39; ph++)
        begin
            ws = $urandom;
            we = ($urandom_range(0, 7) == 0) ? $urandom
                                              : ws + $urandom_range(1, 1 << $urandom_range(1, 30));
            if (ph % 13 == 0) we = ws - $urandom_range(0, 1);
            setup_axis($urandom, $urandom, ws, we);
            for (int i = 0; i < 50; i++)
                send_time(pick_time(), (ph % 4) != 3);
        end

        drain();
        if (fail_count == 0 && pending_points == 0)
            $display("min_jerk_trajectory_point_test: done, clean");
        else
            $display("min_jerk_trajectory_point_test: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("min_jerk_trajectory_point_test: done, errors");
        $finish;
    end

endmodule
